[hdl/hopscotch_hash_insert_defines.svh]
// ----------------------------------------------------------------------------
// hopscotch hash insert assertion macros
// shared assertion forms, clocked on i_clk, quiet while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef HOPSCOTCH_HASH_INSERT_DEFINES_SVH
`define HOPSCOTCH_HASH_INSERT_DEFINES_SVH

// consequence checked in the same cycle
`define HHI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the following cycle
`define HHI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/hhi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhi_pkg
// sizes, entry layout, status codes and hash helpers for the hash insert block
// ----------------------------------------------------------------------------
package hhi_pkg;

    localparam int TABLE_SIZE   = 1024;
    localparam int HOP_RANGE    = 32;
    localparam int INSERT_RANGE = 256;
    localparam int STORE_DEPTH  = TABLE_SIZE + INSERT_RANGE;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int TAB_W        = $clog2(TABLE_SIZE);
    localparam int HOP_W        = $clog2(HOP_RANGE);
    localparam int D_W          = $clog2(INSERT_RANGE + 1);

    localparam logic [31:0] MULT_CONST = 32'd2654435761;

    // result status codes
    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    // one bucket of the table
    typedef struct packed {
        logic        used;
        logic [63:0] key;
        logic [63:0] hash;
        logic [63:0] data;
    } t_entry;

    typedef logic [HOP_RANGE-1:0] t_hop;

    // one round of the integer mix, selected by step number
    function automatic logic [63:0] mix_step(input logic [63:0] k, input logic [2:0] step);
        logic [63:0] r;
        case (step)
            3'd0:    r = k + (k << 12);
            3'd1:    r = k ^ (k >> 22);
            3'd2:    r = k + (k << 4);
            3'd3:    r = k ^ (k >> 9);
            3'd4:    r = k + (k << 10);
            3'd5:    r = k ^ (k >> 2);
            3'd6:    r = k + (k << 7);
            default: r = k ^ (k >> 12);
        endcase
        return r;
    endfunction

endpackage

[hdl/hhi_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhi_req_if
// request channel: key and payload with valid/ready
// ----------------------------------------------------------------------------
interface hhi_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] key;
    logic [63:0] payload;

    modport source (output valid, output key, output payload, input ready);
    modport sink   (input valid, input key, input payload, output ready);
endinterface

[hdl/hhi_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhi_rsp_if
// response channel: result data and status with valid/ready
// ----------------------------------------------------------------------------
interface hhi_rsp_if;
    logic             valid;
    logic             ready;
    logic [63:0]      result_data;
    hhi_pkg::t_status status;

    modport source (output valid, output result_data, output status, input ready);
    modport sink   (input valid, input result_data, input status, output ready);
endinterface

[hdl/hopscotch_hash_insert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hopscotch_hash_insert
// insert-or-find engine for a hopscotch hash table held in block memory
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories clear, one bucket a cycle, with
// ready low. It then handles one item at a time: it accepts the item, runs the
// hash mix rounds and the two multiply steps, fetches the home hop map, then
// walks the hop bits, comparing the entry for each set bit, for the lookup. A
// miss probes buckets in the free search, and each displacement move tries
// candidate distances and then moves an entry; the insert and the result
// follow. Every step works on the entry memory or hop map memory, each with
// one read port and one write port, which sets the pace.
// ----------------------------------------------------------------------------
module hopscotch_hash_insert (
    input  logic i_clk,
    input  logic i_rst_n,
    hhi_req_if.sink   i_req,
    hhi_rsp_if.source o_rsp
);
    import hhi_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MIX, S_MUL0, S_MUL1, S_HOP_RD, S_HOP_WT,
        S_LK, S_LK_CMP, S_FS, S_FS_CMP, S_DS, S_DR, S_DH, S_DM, S_DC,
        S_WR0, S_WR1, S_OUT
    } t_state;

    localparam t_hop HOP_ONE = t_hop'(1);

    // memories
    t_entry mem_ent [STORE_DEPTH];
    t_hop   mem_hop [STORE_DEPTH];

    t_state             r_state;
    logic [ADDR_W-1:0]  r_clr;
    logic [63:0]        r_key;
    logic [63:0]        r_pay;
    logic [63:0]        r_k;
    logic [2:0]         r_step;
    logic [63:0]        r_prod;
    logic [63:0]        r_hash;
    t_hop               r_info;
    logic [D_W-1:0]     r_d;
    logic [ADDR_W-1:0]  r_free;
    logic [D_W-1:0]     r_fdist;
    logic [HOP_W-1:0]   r_dist;
    logic [HOP_W-1:0]   r_i;
    logic [ADDR_W-1:0]  r_src;
    t_entry             r_ent_q;
    t_hop               r_hop_q;
    logic               r_out_v;
    logic [63:0]        r_res_data;
    t_status            r_res_st;

    logic               ent_we;
    logic [ADDR_W-1:0]  ent_waddr;
    logic [ADDR_W-1:0]  ent_raddr;
    t_entry             ent_wdata;
    logic               hop_we;
    logic [ADDR_W-1:0]  hop_waddr;
    logic [ADDR_W-1:0]  hop_raddr;
    t_hop               hop_wdata;

    logic [ADDR_W-1:0]  w_home;
    logic [ADDR_W-1:0]  w_base;
    logic [31:0]        w_mul_a;
    logic [63:0]        w_prod;
    logic               w_found;
    logic [HOP_W-1:0]   w_enc;
    logic               w_match;

    assign w_home  = ADDR_W'(r_hash[TAB_W-1:0]);
    assign w_base  = r_free - ADDR_W'(r_dist);
    assign w_match = r_ent_q.used && (r_ent_q.hash == r_hash) && (r_ent_q.key == r_key);

    // shared 32x32 multiplier for the two partial products
    assign w_mul_a = (r_state == S_MUL0) ? r_k[34:3] : 32'(r_k[63:35]);
    assign w_prod  = 64'(w_mul_a) * 64'(MULT_CONST);

    // lowest hop bit below the current distance
    always_comb begin
        w_found = 1'b0;
        w_enc   = '0;
        for (int j = HOP_RANGE - 1; j >= 0; j--) begin
            if (r_hop_q[j] && (HOP_W'(j) < r_dist)) begin
                w_found = 1'b1;
                w_enc   = HOP_W'(j);
            end
        end
    end

    // memory access control
    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = r_free;
        ent_wdata = r_ent_q;
        ent_raddr = w_home + ADDR_W'(r_d);
        hop_we    = 1'b0;
        hop_waddr = w_home;
        hop_wdata = r_hop_q;
        hop_raddr = w_home;
        unique case (r_state)
            S_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = r_clr;
                ent_wdata = '0;
                hop_we    = 1'b1;
                hop_waddr = r_clr;
                hop_wdata = '0;
            end
            S_DR: begin
                hop_raddr = w_base;
            end
            S_DH: begin
                ent_raddr = w_base + ADDR_W'(w_enc);
            end
            S_DM: begin
                ent_we    = 1'b1;
                ent_waddr = r_free;
                ent_wdata = r_ent_q;
                hop_we    = 1'b1;
                hop_waddr = w_base;
                hop_wdata = (r_info | (HOP_ONE << r_dist)) & ~(HOP_ONE << r_i);
            end
            S_DC: begin
                ent_we    = 1'b1;
                ent_waddr = r_src;
                ent_wdata = '0;
            end
            S_WR1: begin
                ent_we    = 1'b1;
                ent_waddr = r_free;
                ent_wdata = '{used: 1'b1, key: r_key, hash: r_hash, data: r_pay};
                hop_we    = 1'b1;
                hop_waddr = w_home;
                hop_wdata = r_hop_q | (HOP_ONE << r_fdist[HOP_W-1:0]);
            end
            default: ;
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            mem_ent[ent_waddr] <= ent_wdata;
        end
        r_ent_q <= mem_ent[ent_raddr];
    end

    // hop map memory
    always_ff @(posedge i_clk) begin
        if (hop_we) begin
            mem_hop[hop_waddr] <= hop_wdata;
        end
        r_hop_q <= mem_hop[hop_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_out_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(STORE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_key   <= i_req.key;
                        r_pay   <= i_req.payload;
                        r_k     <= i_req.key;
                        r_step  <= '0;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_k    <= mix_step(r_k, r_step);
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'd7) begin
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_prod  <= w_prod;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_hash  <= r_prod + {w_prod[31:0], 32'd0};
                    r_state <= S_HOP_RD;
                end
                S_HOP_RD: begin
                    r_state <= S_HOP_WT;
                end
                S_HOP_WT: begin
                    r_info  <= r_hop_q;
                    r_d     <= '0;
                    r_state <= S_LK;
                end
                // lookup over the home hop map
                S_LK: begin
                    if (r_d == D_W'(HOP_RANGE)) begin
                        r_d     <= '0;
                        r_state <= S_FS;
                    end else if (r_info[r_d[HOP_W-1:0]]) begin
                        r_state <= S_LK_CMP;
                    end else begin
                        r_d <= r_d + 1'b1;
                    end
                end
                S_LK_CMP: begin
                    if (w_match) begin
                        r_res_data <= r_ent_q.data;
                        r_res_st   <= ST_FOUND;
                        r_out_v    <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_state <= S_LK;
                    end
                end
                // nearest free bucket
                S_FS: begin
                    if (r_d == D_W'(INSERT_RANGE)) begin
                        r_res_data <= '0;
                        r_res_st   <= ST_FULL;
                        r_out_v    <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_state <= S_FS_CMP;
                    end
                end
                S_FS_CMP: begin
                    if (!r_ent_q.used) begin
                        r_free  <= w_home + ADDR_W'(r_d);
                        r_fdist <= r_d;
                        r_state <= S_DS;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_state <= S_FS;
                    end
                end
                // displacement toward home
                S_DS: begin
                    if (r_fdist < D_W'(HOP_RANGE)) begin
                        r_state <= S_WR0;
                    end else begin
                        r_dist  <= HOP_W'(HOP_RANGE - 1);
                        r_state <= S_DR;
                    end
                end
                S_DR: begin
                    r_state <= S_DH;
                end
                S_DH: begin
                    if (w_found) begin
                        r_info  <= r_hop_q;
                        r_i     <= w_enc;
                        r_src   <= w_base + ADDR_W'(w_enc);
                        r_state <= S_DM;
                    end else if (r_dist == HOP_W'(1)) begin
                        r_res_data <= '0;
                        r_res_st   <= ST_FULL;
                        r_out_v    <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_dist  <= r_dist - 1'b1;
                        r_state <= S_DR;
                    end
                end
                S_DM: begin
                    r_state <= S_DC;
                end
                S_DC: begin
                    r_free  <= r_src;
                    r_fdist <= r_fdist - (D_W'(r_dist) - D_W'(r_i));
                    r_state <= S_DS;
                end
                // final insert
                S_WR0: begin
                    r_state <= S_WR1;
                end
                S_WR1: begin
                    r_res_data <= r_pay;
                    r_res_st   <= ST_INSERTED;
                    r_out_v    <= 1'b1;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_out_v <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ports
    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_v;
    assign o_rsp.result_data = r_res_data;
    assign o_rsp.status      = r_res_st;

endmodule

[hdl/hhi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhi_checker
// port-level checks on the hash insert block, bound to the top level
// ----------------------------------------------------------------------------
`include "hopscotch_hash_insert_defines.svh"

module hhi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_data,
    input logic [1:0]  i_out_status
);
    import hhi_pkg::*;

    // only the three defined status codes
    `HHI_ASSERT_NOW(a_status_legal, i_out_valid, (i_out_status == ST_FOUND) || (i_out_status == ST_INSERTED) || (i_out_status == ST_FULL), "illegal status")

    // a full table reports zero data
    `HHI_ASSERT_NOW(a_full_zero, i_out_valid && (i_out_status == ST_FULL), i_out_data == 64'd0, "full result with data")

    // no new item while a result waits
    `HHI_ASSERT_NOW(a_one_item, i_out_valid, !i_in_ready, "item accepted while result pending")

    // hashing comes first, no result right after accept
    `HHI_ASSERT_NEXT(a_no_early, i_in_valid && i_in_ready, !i_out_valid, "result too early")

    // stalled result holds
    `HHI_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data) && $stable(i_out_status), "stalled result changed")

endmodule

bind hopscotch_hash_insert hhi_checker u_hhi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_data   (o_rsp.result_data),
    .i_out_status (o_rsp.status)
);
